@@ src/schr_pkg.sv @@
// shared types and constants of the servo chain hub router
package schr_pkg;

   localparam int FRAME_BYTES = 32;
   localparam int ADDR_W = $clog2(FRAME_BYTES);
   localparam int CNT_W = ADDR_W + 1;
   localparam int NPORTS = 4;
   localparam int SHADOW_N = 5;

   localparam logic [1:0] OP_HOST = 2'd0;
   localparam logic [1:0] OP_PORT = 2'd1;
   localparam logic [1:0] OP_TICK = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam logic [2:0] REG_START = 3'd0;
   localparam logic [2:0] REG_END = 3'd1;
   localparam logic [2:0] REG_VERSION = 3'd2;
   localparam logic [2:0] REG_ASSIGN = 3'd3;
   localparam logic [2:0] REG_PROBE = 3'd4;
   localparam logic [2:0] REG_BCAST = 3'd5;

   localparam logic [7:0] CHK_MASK = 8'h7f;
   localparam logic [7:0] VER_B1 = 8'h55;
   localparam logic [7:0] VER_B2 = 8'h03;
   localparam logic [7:0] VER_B4 = 8'h01;
   localparam logic [1:0] POLL_LIMIT = 2'd3;
   localparam logic [1:0] AGREE_MIN = 2'd2;
   localparam logic [4:0] DEST_HOST = 5'h01;
   localparam logic [4:0] DEST_ALL = 5'h1e;
   localparam logic [4:0] DEST_P0 = 5'h02;

   typedef enum logic [2:0] {
      ACT_NONE, ACT_HOST, ACT_PROBE, ACT_ASSIGN, ACT_VERSION, ACT_FWD
   } act_type;

   typedef enum logic [2:0] {
      SRC_DATA, SRC_SIX, SRC_START, SRC_MEM, SRC_END
   } src_type;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_ONE    = 5'b00010,
      ST_SIX    = 5'b00100,
      ST_FWD_RD = 5'b01000,
      ST_FWD_OUT = 5'b10000
   } state_type;

   typedef struct packed {
      logic load;
      logic emit;
      src_type src;
      logic [2:0] six_idx;
      logic [1:0] port_idx;
      logic last;
      logic base_clr;
      logic base_add;
      logic [ADDR_W-1:0] rd_addr;
   } cmd_type;

   typedef struct packed {
      act_type act;
      logic [CNT_W-1:0] fwd_len;
      logic out_free;
   } status_type;

endpackage

@@ src/schr_ctrl.sv @@
// controller: sequences the result bytes of each request
module schr_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  schr_pkg::status_type status,
   output schr_pkg::cmd_type cmd
);
   import schr_pkg::*;

   state_type state_ff, state_in;
   act_type kind_ff, kind_in;
   logic [2:0] idx_ff, idx_in;
   logic [1:0] port_ff, port_in;
   logic [CNT_W-1:0] i_ff, i_in;
   logic [CNT_W-1:0] len_ff, len_in;
   logic more_ports;

   assign req_ready = (state_ff == ST_IDLE);
   assign more_ports = (kind_ff == ACT_ASSIGN) && (port_ff != 2'd3);

   always_comb begin
      state_in = state_ff;
      kind_in = kind_ff;
      idx_in = idx_ff;
      port_in = port_ff;
      i_in = i_ff;
      len_in = len_ff;
      cmd = '0;
      cmd.src = SRC_DATA;
      cmd.six_idx = idx_ff;
      cmd.port_idx = port_ff;
      cmd.rd_addr = ADDR_W'(i_ff - CNT_W'(1));
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               kind_in = status.act;
               idx_in = '0;
               port_in = '0;
               i_in = '0;
               len_in = status.fwd_len;
               cmd.base_clr = 1'b1;
               unique case (status.act)
                  ACT_HOST: state_in = ST_ONE;
                  ACT_PROBE, ACT_ASSIGN, ACT_VERSION: state_in = ST_SIX;
                  ACT_FWD: state_in = ST_FWD_OUT;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_ONE: begin
            cmd.src = SRC_DATA;
            cmd.last = 1'b1;
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_SIX: begin
            cmd.src = SRC_SIX;
            cmd.last = (idx_ff == 3'd5) && !more_ports;
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (idx_ff == 3'd5) begin
                  idx_in = '0;
                  if (more_ports) begin
                     cmd.base_add = 1'b1;
                     port_in = port_ff + 2'd1;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  idx_in = idx_ff + 3'd1;
               end
            end
         end
         ST_FWD_RD: begin
            state_in = ST_FWD_OUT;
         end
         ST_FWD_OUT: begin
            if (i_ff == '0) cmd.src = SRC_START;
            else if (i_ff == len_ff + CNT_W'(1)) cmd.src = SRC_END;
            else cmd.src = SRC_MEM;
            cmd.last = (i_ff == len_ff + CNT_W'(1));
            if (status.out_free) begin
               cmd.emit = 1'b1;
               i_in = i_ff + CNT_W'(1);
               if (cmd.last) state_in = ST_IDLE;
               else if (i_ff == len_ff) state_in = ST_FWD_OUT;
               else state_in = ST_FWD_RD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         kind_ff <= ACT_NONE;
         idx_ff <= '0;
         port_ff <= '0;
         i_ff <= '0;
         len_ff <= '0;
      end else begin
         state_ff <= state_in;
         kind_ff <= kind_in;
         idx_ff <= idx_in;
         port_ff <= port_in;
         i_ff <= i_in;
         len_ff <= len_in;
      end
   end

endmodule

@@ src/schr_dp.sv @@
// datapath: frame parsers, poll debounce, frame store and result register
module schr_dp (
   input  logic clock,
   input  logic reset,
   input  logic [1:0] req_op,
   input  logic [1:0] req_port,
   input  logic [7:0] req_data,
   input  logic rsp_ready,
   output logic rsp_valid,
   output logic [4:0] rsp_dest,
   output logic [7:0] rsp_byte_out,
   output logic rsp_last,
   input  logic csr_we,
   input  logic [2:0] csr_addr,
   input  logic [7:0] csr_wdata,
   input  schr_pkg::cmd_type cmd,
   output schr_pkg::status_type status
);
   import schr_pkg::*;

   logic [7:0] start_ff, end_ff, version_ff, assign_ff, probe_ff, bcast_ff;

   logic host_frame_ff, host_frame_in;
   logic host_ver_ff, host_ver_in;
   logic [CNT_W-1:0] host_cnt_ff, host_cnt_in;
   logic [7:0] shadow_ff [SHADOW_N];
   logic [7:0] shadow_in [SHADOW_N];
   logic ids_ff, ids_in;
   logic [7:0] mem [FRAME_BYTES];
   logic mem_we;
   logic [7:0] rdata_ff;

   logic p_frame_ff [NPORTS];
   logic p_frame_in [NPORTS];
   logic [CNT_W-1:0] p_cnt_ff [NPORTS];
   logic [CNT_W-1:0] p_cnt_in [NPORTS];
   logic [7:0] p_id_ff [NPORTS];
   logic [7:0] p_id_in [NPORTS];
   logic [7:0] p_svc_ff [NPORTS];
   logic [7:0] p_svc_in [NPORTS];
   logic [7:0] rmax_ff [NPORTS];
   logic [7:0] rmax_in [NPORTS];
   logic [7:0] pmax_ff [NPORTS];
   logic [7:0] pmax_in [NPORTS];
   logic [7:0] scnt_ff [NPORTS];
   logic [7:0] scnt_in [NPORTS];
   logic [1:0] poll_ff [NPORTS];
   logic [1:0] poll_in [NPORTS];
   logic [1:0] agree_ff [NPORTS];
   logic [1:0] agree_in [NPORTS];

   act_type act, kind_ff;
   logic [4:0] dest_ff, dest_in, route_dest, ver_dest;
   logic ver_any;
   logic [7:0] data_ff, base_ff;
   logic [9:0] sum0, sum1, sum2, id_ext;
   logic [7:0] six_byte, six_svc, six_val, out_byte;
   logic [4:0] six_dest, out_dest;
   logic [1:0] pc;
   logic [1:0] ac;
   logic [CNT_W-1:0] cnt_inc;

   assign sum0 = {2'b00, scnt_ff[0]};
   assign sum1 = sum0 + {2'b00, scnt_ff[1]};
   assign sum2 = sum1 + {2'b00, scnt_ff[2]};
   assign id_ext = {2'b00, shadow_ff[0]};

   always_comb begin
      priority if (shadow_ff[0] == bcast_ff) route_dest = DEST_ALL;
      else if (id_ext <= sum0) route_dest = 5'h02;
      else if (id_ext <= sum1) route_dest = 5'h04;
      else if (id_ext <= sum2) route_dest = 5'h08;
      else route_dest = 5'h10;
      ver_any = 1'b1;
      priority if (scnt_ff[0] != '0) ver_dest = 5'h02;
      else if (scnt_ff[1] != '0) ver_dest = 5'h04;
      else if (scnt_ff[2] != '0) ver_dest = 5'h08;
      else if (scnt_ff[3] != '0) ver_dest = 5'h10;
      else begin
         ver_dest = 5'h10;
         ver_any = 1'b0;
      end
   end

   assign cnt_inc = host_cnt_ff + CNT_W'(1);

   always_comb begin
      act = ACT_NONE;
      host_frame_in = host_frame_ff;
      host_ver_in = host_ver_ff;
      host_cnt_in = host_cnt_ff;
      ids_in = ids_ff;
      dest_in = dest_ff;
      mem_we = 1'b0;
      pc = '0;
      ac = '0;
      for (int k = 0; k < SHADOW_N; k++) shadow_in[k] = shadow_ff[k];
      for (int p = 0; p < NPORTS; p++) begin
         p_frame_in[p] = p_frame_ff[p];
         p_cnt_in[p] = p_cnt_ff[p];
         p_id_in[p] = p_id_ff[p];
         p_svc_in[p] = p_svc_ff[p];
         rmax_in[p] = rmax_ff[p];
         pmax_in[p] = pmax_ff[p];
         scnt_in[p] = scnt_ff[p];
         poll_in[p] = poll_ff[p];
         agree_in[p] = agree_ff[p];
      end
      unique case (req_op)
         OP_HOST: begin
            if (host_frame_ff) begin
               if (req_data == end_ff) begin
                  host_frame_in = 1'b0;
                  if (shadow_ff[1] == assign_ff) begin
                     act = ACT_ASSIGN;
                     ids_in = 1'b1;
                  end else begin
                     act = ACT_FWD;
                     dest_in = route_dest;
                  end
               end else begin
                  mem_we = 1'b1;
                  for (int k = 0; k < SHADOW_N; k++)
                     if (host_cnt_ff == CNT_W'(k)) shadow_in[k] = req_data;
                  host_cnt_in = cnt_inc;
                  if (cnt_inc > CNT_W'(FRAME_BYTES - 1)) begin
                     host_frame_in = 1'b0;
                     host_cnt_in = '0;
                  end
               end
            end else if (host_ver_ff) begin
               mem_we = 1'b1;
               for (int k = 0; k < SHADOW_N; k++)
                  if (host_cnt_ff == CNT_W'(k)) shadow_in[k] = req_data;
               host_cnt_in = cnt_inc;
               if (cnt_inc >= CNT_W'(5)) begin
                  host_ver_in = 1'b0;
                  host_cnt_in = '0;
                  if (shadow_ff[0] == VER_B1 && shadow_ff[1] == VER_B2 &&
                      shadow_ff[3] == VER_B4 && req_data == 8'h00) begin
                     ids_in = 1'b1;
                     dest_in = ver_dest;
                     if (ver_any) act = ACT_VERSION;
                  end
               end
            end else if (req_data == start_ff) begin
               host_frame_in = 1'b1;
               host_cnt_in = '0;
            end else if (req_data == version_ff) begin
               host_ver_in = 1'b1;
               host_cnt_in = '0;
            end
         end
         OP_PORT: begin
            if (ids_ff) begin
               act = ACT_HOST;
            end else if (p_frame_ff[req_port]) begin
               if (req_data == end_ff) begin
                  p_frame_in[req_port] = 1'b0;
                  if (p_svc_ff[req_port] == probe_ff &&
                      rmax_ff[req_port] < p_id_ff[req_port])
                     rmax_in[req_port] = p_id_ff[req_port];
               end else begin
                  if (p_cnt_ff[req_port] == '0) p_id_in[req_port] = req_data;
                  else if (p_cnt_ff[req_port] == CNT_W'(1)) p_svc_in[req_port] = req_data;
                  p_cnt_in[req_port] = p_cnt_ff[req_port] + CNT_W'(1);
                  if (p_cnt_in[req_port] > CNT_W'(FRAME_BYTES - 1)) begin
                     p_frame_in[req_port] = 1'b0;
                     p_cnt_in[req_port] = '0;
                  end
               end
            end else if (req_data == start_ff) begin
               p_frame_in[req_port] = 1'b1;
               p_cnt_in[req_port] = '0;
            end
         end
         OP_TICK: begin
            if (!ids_ff) begin
               act = ACT_PROBE;
               for (int p = 0; p < NPORTS; p++) begin
                  pc = poll_ff[p] + 2'd1;
                  ac = agree_ff[p] + {1'b0, rmax_ff[p] == pmax_ff[p]};
                  if (pc >= POLL_LIMIT) begin
                     if (ac >= AGREE_MIN) scnt_in[p] = rmax_ff[p];
                     pc = '0;
                     ac = '0;
                  end
                  poll_in[p] = pc;
                  agree_in[p] = ac;
                  pmax_in[p] = rmax_ff[p];
                  rmax_in[p] = '0;
               end
            end
         end
         default: act = ACT_NONE;
      endcase
   end

   assign status.act = act;
   assign status.fwd_len = host_cnt_ff;
   assign status.out_free = !rsp_valid || rsp_ready;

   always_comb begin
      six_svc = (kind_ff == ACT_ASSIGN) ? assign_ff : probe_ff;
      six_val = (kind_ff == ACT_ASSIGN) ? base_ff : 8'h00;
      six_dest = (kind_ff == ACT_ASSIGN) ? (DEST_P0 << cmd.port_idx) : DEST_ALL;
      if (kind_ff == ACT_VERSION) begin
         six_dest = dest_ff;
         unique case (cmd.six_idx)
            3'd0: six_byte = version_ff;
            3'd1: six_byte = VER_B1;
            3'd2: six_byte = VER_B2;
            3'd4: six_byte = VER_B4;
            default: six_byte = 8'h00;
         endcase
      end else begin
         unique case (cmd.six_idx)
            3'd0: six_byte = start_ff;
            3'd1: six_byte = bcast_ff;
            3'd2: six_byte = six_svc;
            3'd3: six_byte = six_val;
            3'd4: six_byte = (bcast_ff + six_svc + six_val) & CHK_MASK;
            default: six_byte = end_ff;
         endcase
      end
      unique case (cmd.src)
         SRC_DATA: begin
            out_byte = data_ff;
            out_dest = DEST_HOST;
         end
         SRC_SIX: begin
            out_byte = six_byte;
            out_dest = six_dest;
         end
         SRC_START: begin
            out_byte = start_ff;
            out_dest = dest_ff;
         end
         SRC_MEM: begin
            out_byte = rdata_ff;
            out_dest = dest_ff;
         end
         default: begin
            out_byte = end_ff;
            out_dest = dest_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we && cmd.load) mem[host_cnt_ff[ADDR_W-1:0]] <= req_data;
      rdata_ff <= mem[cmd.rd_addr];
      if (cmd.load) begin
         data_ff <= req_data;
         kind_ff <= act;
      end
      if (cmd.emit) begin
         rsp_dest <= out_dest;
         rsp_byte_out <= out_byte;
         rsp_last <= cmd.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= 8'hf0;
         end_ff <= 8'hf7;
         version_ff <= 8'hff;
         assign_ff <= 8'h10;
         probe_ff <= 8'h11;
         bcast_ff <= 8'hff;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_START: start_ff <= csr_wdata;
            REG_END: end_ff <= csr_wdata;
            REG_VERSION: version_ff <= csr_wdata;
            REG_ASSIGN: assign_ff <= csr_wdata;
            REG_PROBE: probe_ff <= csr_wdata;
            REG_BCAST: bcast_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
         host_frame_ff <= 1'b0;
         host_ver_ff <= 1'b0;
         host_cnt_ff <= '0;
         ids_ff <= 1'b0;
         dest_ff <= DEST_ALL;
         base_ff <= '0;
         for (int k = 0; k < SHADOW_N; k++) shadow_ff[k] <= '0;
         for (int p = 0; p < NPORTS; p++) begin
            p_frame_ff[p] <= 1'b0;
            p_cnt_ff[p] <= '0;
            p_id_ff[p] <= '0;
            p_svc_ff[p] <= '0;
            rmax_ff[p] <= '0;
            pmax_ff[p] <= '0;
            scnt_ff[p] <= '0;
            poll_ff[p] <= '0;
            agree_ff[p] <= '0;
         end
      end else begin
         if (cmd.emit) rsp_valid <= 1'b1;
         else if (rsp_ready) rsp_valid <= 1'b0;
         if (cmd.base_clr) base_ff <= '0;
         else if (cmd.base_add) base_ff <= base_ff + scnt_ff[cmd.port_idx];
         if (cmd.load) begin
            host_frame_ff <= host_frame_in;
            host_ver_ff <= host_ver_in;
            host_cnt_ff <= host_cnt_in;
            ids_ff <= ids_in;
            dest_ff <= dest_in;
            for (int k = 0; k < SHADOW_N; k++) shadow_ff[k] <= shadow_in[k];
            for (int p = 0; p < NPORTS; p++) begin
               p_frame_ff[p] <= p_frame_in[p];
               p_cnt_ff[p] <= p_cnt_in[p];
               p_id_ff[p] <= p_id_in[p];
               p_svc_ff[p] <= p_svc_in[p];
               rmax_ff[p] <= rmax_in[p];
               pmax_ff[p] <= pmax_in[p];
               scnt_ff[p] <= scnt_in[p];
               poll_ff[p] <= poll_in[p];
               agree_ff[p] <= agree_in[p];
            end
         end
      end
   end

endmodule

@@ src/servo_chain_hub_router_top.sv @@
// top level of the servo chain hub router
//
// one request channel (req_op, req_port, req_data) carries host bytes,
// downstream bytes and poll ticks; the response channel (rsp_dest,
// rsp_byte_out, rsp_last) carries bytes to transmit with a destination mask,
// rsp_last marking the final byte caused by a request.
// a request that produces nothing is taken without occupying the block. a request with
// results occupies the block until its last byte enters the output register:
// one byte per cycle while the output is free for probe, assign and version
// frames (6, 24 or 6 bytes); each stored byte of a forwarded host frame, up
// to a full frame of 31, passes a read state and an output state because the
// frame store read is registered. req_ready is high whenever no response sequence is in progress.
// a stalled receiver (rsp_ready low) holds the output register and the
// sequencer waits; a new request may be taken while the last byte waits.
// reset is synchronous and returns all parser, poll and id state to zero
// and the code registers to their defaults; the csr port writes them.
module servo_chain_hub_router_top (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [1:0] req_op,
   input  logic [1:0] req_port,
   input  logic [7:0] req_data,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [4:0] rsp_dest,
   output logic [7:0] rsp_byte_out,
   output logic rsp_last,
   input  logic csr_we,
   input  logic [2:0] csr_addr,
   input  logic [7:0] csr_wdata
);
   import schr_pkg::*;

   cmd_type cmd;
   status_type status;

   schr_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .status(status),
      .cmd(cmd)
   );

   schr_dp u_dp (
      .clock(clock),
      .reset(reset),
      .req_op(req_op),
      .req_port(req_port),
      .req_data(req_data),
      .rsp_ready(rsp_ready),
      .rsp_valid(rsp_valid),
      .rsp_dest(rsp_dest),
      .rsp_byte_out(rsp_byte_out),
      .rsp_last(rsp_last),
      .csr_we(csr_we),
      .csr_addr(csr_addr),
      .csr_wdata(csr_wdata),
      .cmd(cmd),
      .status(status)
   );

endmodule

@@ src/schr_checker.sv @@
// port checker of the servo chain hub router and its bind
module schr_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic [1:0] req_op,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [4:0] rsp_dest,
   input logic [7:0] rsp_byte_out,
   input logic rsp_last
);
   import schr_pkg::*;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_dest) &&
      $stable(rsp_byte_out) && $stable(rsp_last))
      else $error("stalled response changed");

   a_dest: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_dest != 5'd0)
      else $error("response without destination");

   a_unused_op: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_op == OP_UNUSED |=> req_ready)
      else $error("unused op blocked the request channel");

   a_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind servo_chain_hub_router_top schr_checker u_schr_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_valid),
   .req_ready(req_ready),
   .req_op(req_op),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_dest(rsp_dest),
   .rsp_byte_out(rsp_byte_out),
   .rsp_last(rsp_last)
);

@@ tb/sv/servo_chain_hub_router_top_test.sv @@
// testbench of the servo chain hub router: directed and random requests checked against a predictor
`timescale 1ns / 100ps

module servo_chain_hub_router_top_test;
   import schr_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_op = OP_HOST;
   logic [1:0] req_port = 2'd0;
   logic [7:0] req_data = 8'd0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [4:0] rsp_dest;
   logic [7:0] rsp_byte_out;
   logic rsp_last;
   logic csr_we = 1'b0;
   logic [2:0] csr_addr = REG_START;
   logic [7:0] csr_wdata = 8'd0;

   typedef struct packed {
      logic [4:0] dest;
      logic [7:0] byte_out;
      logic last;
   } tx_byte_type;

   tx_byte_type tx_expected[$];
   int errors = 0;
   int requests_sent = 0;
   int bytes_checked = 0;
   int cycles = 0;
   int stall_mode = 0;

   // predictor state
   logic [7:0] c_start, c_end, c_version, c_assign, c_probe, c_bcast;
   logic h_in_frame, h_in_version, ids_done;
   logic [5:0] h_count;
   logic [7:0] h_frame[FRAME_BYTES];
   logic p_in_frame[NPORTS];
   logic [5:0] p_count[NPORTS];
   logic [7:0] p_id[NPORTS], p_svc[NPORTS], run_max[NPORTS], prev_max[NPORTS];
   logic [7:0] servo_cnt[NPORTS];
   logic [1:0] poll_cnt[NPORTS], agree_cnt[NPORTS];
   tx_byte_type step_out[$];

   servo_chain_hub_router_top i_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 1000000) begin
         $display("tb: failure");
         $finish;
      end
   end

   // receiver stall patterns
   always @(negedge clock) begin
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 3) != 0);
         2: rsp_ready <= (cycles % 7) < 3;
         default: rsp_ready <= ($urandom_range(0, 9) == 0);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         tx_byte_type exp_b;
         if (tx_expected.size() == 0) begin
            $display("%0t unexpected byte dest %h byte %h last %b", $time, rsp_dest,
               rsp_byte_out, rsp_last);
            errors++;
         end else begin
            exp_b = tx_expected.pop_front();
            bytes_checked++;
            if (exp_b.dest !== rsp_dest) begin
               $display("%0t dest expected %h actual %h", $time, exp_b.dest, rsp_dest);
               errors++;
            end
            if (exp_b.byte_out !== rsp_byte_out) begin
               $display("%0t byte expected %h actual %h", $time, exp_b.byte_out,
                  rsp_byte_out);
               errors++;
            end
            if (exp_b.last !== rsp_last) begin
               $display("%0t last expected %b actual %b", $time, exp_b.last, rsp_last);
               errors++;
            end
         end
      end
   end

   function automatic void hub_reset();
      c_start = 8'hf0; c_end = 8'hf7; c_version = 8'hff;
      c_assign = 8'h10; c_probe = 8'h11; c_bcast = 8'hff;
      h_in_frame = 0; h_in_version = 0; h_count = 0; ids_done = 0;
      for (int i = 0; i < FRAME_BYTES; i++) h_frame[i] = 0;
      for (int p = 0; p < NPORTS; p++) begin
         p_in_frame[p] = 0; p_count[p] = 0; p_id[p] = 0; p_svc[p] = 0;
         run_max[p] = 0; prev_max[p] = 0; servo_cnt[p] = 0;
         poll_cnt[p] = 0; agree_cnt[p] = 0;
      end
   endfunction

   function automatic void emit(logic [4:0] dest, logic [7:0] b);
      tx_byte_type t;
      t.dest = dest; t.byte_out = b; t.last = 1'b0;
      step_out.push_back(t);
   endfunction

   function automatic void emit_service(logic [4:0] dest, logic [7:0] svc, logic [7:0] val);
      emit(dest, c_start); emit(dest, c_bcast); emit(dest, svc); emit(dest, val);
      emit(dest, (c_bcast + svc + val) & CHK_MASK); emit(dest, c_end);
   endfunction

   function automatic void route_host_frame();
      logic [7:0] base;
      logic [4:0] dest;
      int id, s0, s1, s2;
      if (h_frame[1] == c_assign) begin
         base = 0;
         ids_done = 1;
         for (int p = 0; p < NPORTS; p++) begin
            emit_service(DEST_P0 << p, c_assign, base);
            base = base + servo_cnt[p];
         end
         return;
      end
      id = h_frame[0]; s0 = servo_cnt[0]; s1 = s0 + servo_cnt[1]; s2 = s1 + servo_cnt[2];
      if (h_frame[0] == c_bcast) dest = DEST_ALL;
      else if (id <= s0) dest = 5'h02;
      else if (id <= s1) dest = 5'h04;
      else if (id <= s2) dest = 5'h08;
      else dest = 5'h10;
      emit(dest, c_start);
      for (int i = 0; i < h_count && i < FRAME_BYTES; i++) emit(dest, h_frame[i]);
      emit(dest, c_end);
   endfunction

   function automatic void hub_step(logic [1:0] op, logic [1:0] port, logic [7:0] d);
      step_out.delete();
      if (op == OP_HOST) begin
         if (h_in_frame) begin
            if (d == c_end) begin
               h_in_frame = 0;
               route_host_frame();
            end else begin
               if (h_count < FRAME_BYTES) h_frame[h_count] = d;
               h_count++;
               if (h_count > FRAME_BYTES - 1) begin h_in_frame = 0; h_count = 0; end
            end
         end else if (h_in_version) begin
            if (h_count < FRAME_BYTES) h_frame[h_count] = d;
            h_count++;
            if (h_count >= 5) begin
               h_in_version = 0; h_count = 0;
               if (h_frame[0] == VER_B1 && h_frame[1] == VER_B2 && h_frame[3] == VER_B4
                   && h_frame[4] == 8'h00) begin
                  ids_done = 1;
                  for (int p = 0; p < NPORTS; p++) begin
                     if (servo_cnt[p] != 0) begin
                        emit(DEST_P0 << p, c_version); emit(DEST_P0 << p, VER_B1);
                        emit(DEST_P0 << p, VER_B2); emit(DEST_P0 << p, 8'h00);
                        emit(DEST_P0 << p, VER_B4); emit(DEST_P0 << p, 8'h00);
                        break;
                     end
                  end
               end
            end
         end else if (d == c_start) begin
            h_in_frame = 1; h_count = 0;
         end else if (d == c_version) begin
            h_in_version = 1; h_count = 0;
         end
      end else if (op == OP_PORT) begin
         if (ids_done) emit(DEST_HOST, d);
         else if (p_in_frame[port]) begin
            if (d == c_end) begin
               p_in_frame[port] = 0;
               if (p_svc[port] == c_probe && run_max[port] < p_id[port])
                  run_max[port] = p_id[port];
            end else begin
               if (p_count[port] == 0) p_id[port] = d;
               else if (p_count[port] == 1) p_svc[port] = d;
               p_count[port]++;
               if (p_count[port] > FRAME_BYTES - 1) begin
                  p_in_frame[port] = 0; p_count[port] = 0;
               end
            end
         end else if (d == c_start) begin
            p_in_frame[port] = 1; p_count[port] = 0;
         end
      end else if (op == OP_TICK && !ids_done) begin
         emit_service(DEST_ALL, c_probe, 8'h00);
         for (int p = 0; p < NPORTS; p++) begin
            poll_cnt[p]++;
            if (run_max[p] == prev_max[p]) agree_cnt[p]++;
            if (poll_cnt[p] >= POLL_LIMIT) begin
               if (agree_cnt[p] >= AGREE_MIN) servo_cnt[p] = run_max[p];
               poll_cnt[p] = 0; agree_cnt[p] = 0;
            end
            prev_max[p] = run_max[p];
            run_max[p] = 0;
         end
      end
      if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
      foreach (step_out[i]) tx_expected.push_back(step_out[i]);
   endfunction

   // sends one request; valid stays high across back to back requests unless a random gap drops it first
   task automatic send_request(logic [1:0] op, logic [1:0] port, logic [7:0] d);
      @(negedge clock);
      if ($urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_valid <= 1'b1; req_op <= op; req_port <= port; req_data <= d;
      while (!req_ready) @(negedge clock);
      @(posedge clock);
      hub_step(op, port, d);
      requests_sent++;
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (tx_expected.size() != 0) @(negedge clock);
      repeat (80) @(negedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [7:0] v);
      @(negedge clock);
      csr_we <= 1'b1; csr_addr <= idx; csr_wdata <= v;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_START: c_start = v;
         REG_END: c_end = v;
         REG_VERSION: c_version = v;
         REG_ASSIGN: c_assign = v;
         REG_PROBE: c_probe = v;
         default: c_bcast = v;
      endcase
   endtask

   task automatic host_frame_send(logic [7:0] id, logic [7:0] svc, int payload);
      send_request(OP_HOST, 0, c_start);
      send_request(OP_HOST, 0, id);
      send_request(OP_HOST, 0, svc);
      for (int i = 0; i < payload; i++) send_request(OP_HOST, 0, $urandom_range(0, 255));
      send_request(OP_HOST, 0, c_end);
   endtask

   task automatic probe_reply(logic [1:0] port, logic [7:0] id);
      send_request(OP_PORT, port, c_start);
      send_request(OP_PORT, port, id);
      send_request(OP_PORT, port, c_probe);
      send_request(OP_PORT, port, 8'h00);
      send_request(OP_PORT, port, c_end);
   endtask

   // three polls, each after random probe replies from most ports, so counts may latch
   task automatic settle_counts(int maxid);
      for (int k = 0; k < 3; k++) begin
         for (int p = 0; p < NPORTS; p++)
            if ($urandom_range(0, 4) != 0) probe_reply(p, $urandom_range(0, maxid));
         send_request(OP_TICK, 0, 0);
      end
   endtask

   task automatic test_directed();
      send_request(OP_UNUSED, 2'd3, 8'hff);
      send_request(OP_TICK, 0, 8'h00);
      send_request(OP_PORT, 1, 8'h00);
      send_request(OP_HOST, 0, c_start);
      send_request(OP_HOST, 0, c_end);
      host_frame_send(8'hff, 8'h00, 2);
      host_frame_send(8'h00, 8'hff, 0);
      probe_reply(0, 8'd3);
      probe_reply(1, 8'd5);
      probe_reply(2, 8'd255);
      send_request(OP_TICK, 0, 8'hff);
   endtask

   task automatic test_overflow();
      send_request(OP_HOST, 0, c_start);
      for (int i = 0; i < FRAME_BYTES + 2; i++) send_request(OP_HOST, 0, 8'h01);
      send_request(OP_PORT, 3, c_start);
      for (int i = 0; i < FRAME_BYTES + 2; i++) send_request(OP_PORT, 3, 8'h02);
      host_frame_send(8'h01, 8'h02, FRAME_BYTES - 4);
      drain();
   endtask

   task automatic test_version();
      send_request(OP_HOST, 0, c_version);
      send_request(OP_HOST, 0, VER_B1); send_request(OP_HOST, 0, 8'h00);
      send_request(OP_HOST, 0, 8'h00); send_request(OP_HOST, 0, VER_B4);
      send_request(OP_HOST, 0, 8'h00);
      settle_counts(8);
      send_request(OP_HOST, 0, c_version);
      send_request(OP_HOST, 0, VER_B1); send_request(OP_HOST, 0, VER_B2);
      send_request(OP_HOST, 0, $urandom_range(0, 255));
      send_request(OP_HOST, 0, VER_B4); send_request(OP_HOST, 0, 8'h00);
      send_request(OP_TICK, 0, 0);
      for (int i = 0; i < 6; i++) send_request(OP_PORT, $urandom_range(0, 3), $urandom);
      drain();
   endtask

   task automatic test_random_session(int n);
      int kind;
      if (!ids_done) settle_counts($urandom_range(0, 1) ? 12 : 255);
      for (int i = 0; i < n; i++) begin
         kind = $urandom_range(0, 9);
         if (kind < 4)
            host_frame_send($urandom_range(0, 1) ? c_bcast : $urandom_range(0, 40),
               $urandom_range(0, 255), $urandom_range(0, 4));
         else if (kind < 6)
            probe_reply($urandom_range(0, 3), $urandom_range(0, 255));
         else if (kind < 7)
            send_request(OP_TICK, 0, $urandom);
         else if (kind < 8)
            host_frame_send($urandom_range(0, 30), c_assign, 1);
         else
            send_request($urandom_range(0, 3), $urandom_range(0, 3), $urandom);
      end
      drain();
   endtask

   task automatic test_codes();
      write_reg(REG_START, 8'h00); write_reg(REG_END, 8'hff);
      write_reg(REG_VERSION, 8'h00); write_reg(REG_ASSIGN, 8'hff);
      write_reg(REG_PROBE, 8'h00); write_reg(REG_BCAST, 8'h00);
      test_random_session(3);
      write_reg(REG_START, 8'h5a); write_reg(REG_END, 8'ha5);
      write_reg(REG_VERSION, 8'h3c); write_reg(REG_ASSIGN, 8'h21);
      write_reg(REG_PROBE, 8'h42); write_reg(REG_BCAST, 8'hfe);
      test_random_session(3);
   endtask

   initial begin
      hub_reset();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      stall_mode = 0;
      test_directed();
      drain();
      stall_mode = 1;
      test_overflow();
      test_version();
      stall_mode = 2;
      test_codes();
      stall_mode = 3;
      test_random_session(3);
      stall_mode = 1;
      write_reg(REG_START, 8'hf0); write_reg(REG_END, 8'hf7);
      write_reg(REG_VERSION, 8'hff); write_reg(REG_ASSIGN, 8'h10);
      write_reg(REG_PROBE, 8'h11); write_reg(REG_BCAST, 8'hff);
      test_random_session(3);
      drain();
      $display("covered %0d requests and %0d response bytes over routing, probes,",
         requests_sent, bytes_checked);
      $display("assignment, version, overflow and several code settings");
      if (errors == 0 && tx_expected.size() == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end
endmodule

@@ servo_chain_hub_router_top.f @@
src/schr_pkg.sv
src/schr_ctrl.sv
src/schr_dp.sv
src/servo_chain_hub_router_top.sv
src/schr_checker.sv
tb/sv/servo_chain_hub_router_top_test.sv
